>>> hw/rtl/tssb_pkg.sv
// Shared constants and types of the timestamped sample history buffer.
`default_nettype none

package tssb_pkg;

  localparam int unsigned DefaultDepth = 512;

  localparam logic [15:0] ValidWindowReset  = 16'd300;
  localparam logic [15:0] FreshTimeoutReset = 16'd500;

  localparam int unsigned PaddrWidth = 3;

  typedef enum logic {
    REG_VALID_WINDOW  = 1'b0,
    REG_FRESH_TIMEOUT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEWEST,
    ST_OLDEST,
    ST_SCAN
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/timestamp_sync_sample_buffer_top.sv
// Timestamped sample history buffer with nearest-time lookup, held in one ring memory.
//
//   channel  direction  signals                                        handshake
//   in       sink       cmd, sample_time, sample_value, query_time,    in_valid/in_ready
//                       now_time
//   out      source     ok, match_value, match_time                    out_valid/out_ready
//   apb      slave      psel, penable, pwrite, paddr, pwdata, prdata   pready tied high
//
// An insert is accepted, then checked against one read of the newest entry.
// A query is paced by the single memory read port, which walks the ring one
// entry a cycle from newest towards oldest.
// Reset empties the ring through its fill count; no clearing pass is needed.
// A finished result waits in the output register; while it is not taken the
// next result holds its state and rereads the same entry.
`default_nettype none

module timestamp_sync_sample_buffer_top #(
  parameter int unsigned DEPTH = tssb_pkg::DefaultDepth
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire                             cmd_i,
  input  wire  [31:0]                     sample_time_i,
  input  wire  [31:0]                     sample_value_i,
  input  wire  [31:0]                     query_time_i,
  input  wire  [31:0]                     now_time_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            ok_o,
  output logic [31:0]                     match_value_o,
  output logic [31:0]                     match_time_o,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [tssb_pkg::PaddrWidth-1:0] paddr,
  input  wire  [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tssb_pkg::state_e state_q, state_d;

  logic [63:0]   mem [DEPTH];
  logic [63:0]   rdata_q;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          mem_we;
  logic [AW-1:0] mem_wa;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [AW-1:0] scan_q, scan_d;
  logic [31:0]   ft_q, ft_d;
  logic [31:0]   fv_q, fv_d;

  logic          cmd_q;
  logic [31:0]   st_q, sv_q, qt_q, nt_q;

  logic [15:0]   valid_window_q, fresh_timeout_q;

  logic          out_valid_q, out_ok_q;
  logic [31:0]   out_value_q, out_time_q;

  logic          res_want, res_ok, emit, out_free;
  logic [31:0]   res_value, res_time;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0] newest_age, scan_m1;
  logic [31:0]   rt, rv;
  logic [31:0]   win32, fresh32;
  logic          cfg_write;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] oldest,
                                            input logic [AW-1:0] age);
    logic [AW:0] s;
    s = {1'b0, oldest} + {1'b0, age};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return (s < (AW+1)'(DEPTH)) ? s[AW-1:0] : '0;
  endfunction

  assign cnt_m1     = count_q - CW'(1);
  assign cnt_m2     = count_q - CW'(2);
  assign newest_age = cnt_m1[AW-1:0];
  assign scan_m1    = scan_q - AW'(1);
  assign rt         = rdata_q[63:32];
  assign rv         = rdata_q[31:0];
  assign win32      = {16'd0, valid_window_q};
  assign fresh32    = {16'd0, fresh_timeout_q};
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = res_want && out_free;

  assign in_ready_o    = (state_q == tssb_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign match_value_o = out_value_q;
  assign match_time_o  = out_time_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (tssb_pkg::reg_idx_e'(paddr[2]))
      tssb_pkg::REG_VALID_WINDOW:  prdata = {16'd0, valid_window_q};
      tssb_pkg::REG_FRESH_TIMEOUT: prdata = {16'd0, fresh_timeout_q};
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tssb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tssb_pkg::ST_NEWEST;
        end
      end
      tssb_pkg::ST_NEWEST: begin
        if (!res_want) begin
          state_d = tssb_pkg::ST_OLDEST;
        end else if (emit) begin
          state_d = tssb_pkg::ST_IDLE;
        end
      end
      tssb_pkg::ST_OLDEST: begin
        if (!res_want) begin
          state_d = tssb_pkg::ST_SCAN;
        end else if (emit) begin
          state_d = tssb_pkg::ST_IDLE;
        end
      end
      tssb_pkg::ST_SCAN: begin
        if (emit) begin
          state_d = tssb_pkg::ST_IDLE;
        end
      end
      default: state_d = tssb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr_d = rd_addr_q;
    mem_we    = 1'b0;
    mem_wa    = oldest_q;
    count_d   = count_q;
    oldest_d  = oldest_q;
    scan_d    = scan_q;
    ft_d      = ft_q;
    fv_d      = fv_q;
    res_want  = 1'b0;
    res_ok    = 1'b0;
    res_value = '0;
    res_time  = '0;
    case (state_q)
      tssb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          rd_addr_d = slot_of(oldest_q, newest_age);
        end
      end
      tssb_pkg::ST_NEWEST: begin
        if (tssb_pkg::cmd_e'(cmd_q) == tssb_pkg::CMD_INSERT) begin
          res_want = 1'b1;
          if (count_q == '0 || rt < st_q) begin
            res_ok = 1'b1;
            if (emit) begin
              mem_we = 1'b1;
              if (count_q < CW'(DEPTH)) begin
                mem_wa  = slot_of(oldest_q, count_q[AW-1:0]);
                count_d = count_q + CW'(1);
              end else begin
                mem_wa   = oldest_q;
                oldest_d = slot_of(oldest_q, AW'(1));
              end
            end
          end
        end else if (count_q == '0 || (nt_q - rt) > fresh32) begin
          res_want = 1'b1;
        end else if (qt_q >= rt) begin
          res_want  = 1'b1;
          res_ok    = (qt_q - rt) < win32;
          res_value = rv;
          res_time  = rt;
        end else begin
          ft_d      = rt;
          fv_d      = rv;
          rd_addr_d = oldest_q;
        end
      end
      tssb_pkg::ST_OLDEST: begin
        if (qt_q <= rt) begin
          res_want  = 1'b1;
          res_ok    = (rt - qt_q) < win32;
          res_value = rv;
          res_time  = rt;
        end else begin
          scan_d    = cnt_m2[AW-1:0];
          rd_addr_d = slot_of(oldest_q, cnt_m2[AW-1:0]);
        end
      end
      tssb_pkg::ST_SCAN: begin
        if (qt_q < rt) begin
          ft_d      = rt;
          fv_d      = rv;
          scan_d    = scan_m1;
          rd_addr_d = slot_of(oldest_q, scan_m1);
        end else begin
          res_want = 1'b1;
          if (qt_q == rt) begin
            res_ok    = 1'b1;
            res_value = rv;
            res_time  = rt;
          end else if ((qt_q - rt) <= win32 && (ft_q - qt_q) <= win32) begin
            res_ok = 1'b1;
            if ((qt_q - rt) > (ft_q - qt_q)) begin
              res_value = fv_q;
              res_time  = ft_q;
            end else begin
              res_value = rv;
              res_time  = rt;
            end
          end
        end
      end
      default: ;
    endcase
    if (!res_ok) begin
      res_value = '0;
      res_time  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= {st_q, sv_q};
    end
    rdata_q <= mem[rd_addr_d];
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    scan_q    <= scan_d;
    ft_q      <= ft_d;
    fv_q      <= fv_d;
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      st_q  <= sample_time_i;
      sv_q  <= sample_value_i;
      qt_q  <= query_time_i;
      nt_q  <= now_time_i;
    end
    if (emit) begin
      out_ok_q    <= res_ok;
      out_value_q <= res_value;
      out_time_q  <= res_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= tssb_pkg::ST_IDLE;
      count_q         <= '0;
      oldest_q        <= '0;
      out_valid_q     <= 1'b0;
      valid_window_q  <= tssb_pkg::ValidWindowReset;
      fresh_timeout_q <= tssb_pkg::FreshTimeoutReset;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        case (tssb_pkg::reg_idx_e'(paddr[2]))
          tssb_pkg::REG_VALID_WINDOW:  valid_window_q  <= pwdata[15:0];
          tssb_pkg::REG_FRESH_TIMEOUT: fresh_timeout_q <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Fill count exceeds the ring depth.");

  a_oldest_moves_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != $past(oldest_q)) |-> ($past(count_q) == CW'(DEPTH)))
    else $error("Oldest slot moved while the ring was not full.");

  a_fail_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (match_value_o == '0 && match_time_o == '0))
    else $error("A failed result carries a non-zero sample.");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == tssb_pkg::ST_NEWEST))
    else $error("An accepted item did not start its lookup.");

  a_write_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (emit && res_ok && state_q == tssb_pkg::ST_NEWEST))
    else $error("The ring was written outside an accepted insert.");

endmodule

`default_nettype wire
